@@ design/assert_macros.svh @@
// Assertion helpers for the checker file.
// Both forms sample on the rising edge of clk and stay quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that holds at every clock edge outside reset.
`define TBO_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition at one edge implies a consequence at the next edge.
`define TBO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tbo_pkg.sv @@
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared types, widths and register codes of the triangle/box overlap test.
// ----------------------------------------------------------------------------
`default_nettype none

package tbo_pkg;

	localparam int COORD_W  = 24;
	localparam int EDGE_W   = COORD_W + 1;
	localparam int NPRD_W   = 2 * EDGE_W;
	localparam int NRM_W    = NPRD_W + 1;
	localparam int NLO_W    = (NRM_W + 1) / 2;
	localparam int NHI_W    = NRM_W - NLO_W;
	localparam int PL_W     = NLO_W + 1 + COORD_W;
	localparam int PH_W     = NHI_W + COORD_W;
	localparam int FULL_W   = NRM_W + COORD_W;
	localparam int SUM_W    = FULL_W + 2;
	localparam int EPRD_W   = EDGE_W + COORD_W;
	localparam int EDOT_W   = EPRD_W + 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int BACK_STAGES = 7;
	localparam int CAPACITY    = QUEUE_DEPTH + BACK_STAGES + 1;
	localparam int OCNT_W      = $clog2(CAPACITY + 1);

	localparam int APB_W     = 32;
	localparam int REG_NUM   = 6;
	localparam int REG_IDX_W = $clog2(REG_NUM);
	localparam int ADDR_W    = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_MIN_X = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_MAX_X = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_MIN_Y = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_MAX_Y = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_MIN_Z = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_MAX_Z = REG_IDX_W'(5);

	// Cyclic successors of an axis or vertex index.
	localparam int NXT1 [3] = '{1, 2, 0};
	localparam int NXT2 [3] = '{2, 0, 1};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [EDGE_W-1:0]  edge_t;

	typedef struct packed {
		coord_t [2:0] lo;
		coord_t [2:0] hi;
	} box_t;

	typedef struct packed {
		coord_t [2:0][2:0] v;
		edge_t  [2:0][2:0] e;
		logic              box_sep;
	} item_t;

endpackage

`default_nettype wire

@@ design/tbo_front.sv @@
// ----------------------------------------------------------------------------
// tbo_front
// Classifies an incoming triangle: edge vectors and the box-axis verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_front (
	input  tbo_pkg::coord_t v0_x,
	input  tbo_pkg::coord_t v0_y,
	input  tbo_pkg::coord_t v0_z,
	input  tbo_pkg::coord_t v1_x,
	input  tbo_pkg::coord_t v1_y,
	input  tbo_pkg::coord_t v1_z,
	input  tbo_pkg::coord_t v2_x,
	input  tbo_pkg::coord_t v2_y,
	input  tbo_pkg::coord_t v2_z,
	input  tbo_pkg::box_t   box,
	output tbo_pkg::item_t  item
);

	tbo_pkg::coord_t vv [3][3];

	assign vv[0][0] = v0_x;
	assign vv[0][1] = v0_y;
	assign vv[0][2] = v0_z;
	assign vv[1][0] = v1_x;
	assign vv[1][1] = v1_y;
	assign vv[1][2] = v1_z;
	assign vv[2][0] = v2_x;
	assign vv[2][1] = v2_y;
	assign vv[2][2] = v2_z;

	always_comb begin
		tbo_pkg::coord_t mn;
		tbo_pkg::coord_t mx;
		logic sep;
		sep = 1'b0;
		for (int k = 0; k < 3; k++) begin
			mn = vv[0][k];
			mx = vv[0][k];
			for (int m = 1; m < 3; m++) begin
				if (vv[m][k] < mn) mn = vv[m][k];
				if (vv[m][k] > mx) mx = vv[m][k];
			end
			if ((mx < $signed(box.lo[k])) || (mn > $signed(box.hi[k]))) sep = 1'b1;
		end
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				item.v[i][k] = vv[i][k];
				// Edge i runs from vertex i+1 to vertex i.
				item.e[i][k] = tbo_pkg::edge_t'(vv[i][k])
					- tbo_pkg::edge_t'(vv[tbo_pkg::NXT1[i]][k]);
			end
		end
		item.box_sep = sep;
	end

endmodule

`default_nettype wire

@@ design/tbo_queue.sv @@
// ----------------------------------------------------------------------------
// tbo_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tbo_pkg::item_t din,
	input  logic           pop,
	output tbo_pkg::item_t dout,
	output logic           full,
	output logic           empty
);

	tbo_pkg::item_t                     mem_q [tbo_pkg::QUEUE_DEPTH];
	logic [tbo_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [tbo_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [tbo_pkg::QCNT_W-1:0]         count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = (count_q == tbo_pkg::QCNT_W'(tbo_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ design/tbo_back.sv @@
// ----------------------------------------------------------------------------
// tbo_back
// Seven-stage arithmetic pipeline: plane-normal and edge-axis tests.
// ----------------------------------------------------------------------------
`default_nettype none

module tbo_back (
	input  logic           clk,
	input  logic           arst_n,
	input  tbo_pkg::item_t head,
	input  logic           head_valid,
	input  tbo_pkg::box_t  box,
	output logic           pop,
	input  logic           out_stall,
	output logic           out_valid,
	output logic           overlaps
);

	localparam int NLO = tbo_pkg::NLO_W;

	logic adv;
	logic [tbo_pkg::BACK_STAGES-1:0] vld_q;
	logic out_valid_q;
	logic overlaps_q;

	tbo_pkg::coord_t lo [3];
	tbo_pkg::coord_t hi [3];

	// Stage 1: all first-level products.
	logic signed [tbo_pkg::NPRD_W-1:0] np_s1 [3][2];
	logic signed [tbo_pkg::EPRD_W-1:0] tp_s1 [3][3][3][2];
	logic signed [tbo_pkg::EPRD_W-1:0] bp_s1 [3][3][4];
	logic                              skip_s1 [3][3];
	tbo_pkg::coord_t                   v0_s1 [3];
	logic                              bsep_s1;
	// Stage 2
	logic signed [tbo_pkg::NRM_W-1:0]  n_s2 [3];
	logic signed [tbo_pkg::EDOT_W-1:0] td_s2 [3][3][3];
	logic signed [tbo_pkg::EPRD_W-1:0] pq_min_s2 [3][3];
	logic signed [tbo_pkg::EPRD_W-1:0] pq_max_s2 [3][3];
	logic signed [tbo_pkg::EPRD_W-1:0] rs_min_s2 [3][3];
	logic signed [tbo_pkg::EPRD_W-1:0] rs_max_s2 [3][3];
	logic                              skip_s2 [3][3];
	tbo_pkg::coord_t                   v0_s2 [3];
	logic                              bsep_s2;
	// Stage 3
	logic signed [tbo_pkg::PL_W-1:0]   pl_s3 [3][3];
	logic signed [tbo_pkg::PH_W-1:0]   ph_s3 [3][3];
	logic signed [tbo_pkg::EDOT_W-1:0] tmin_s3 [3][3];
	logic signed [tbo_pkg::EDOT_W-1:0] tmax_s3 [3][3];
	logic signed [tbo_pkg::EDOT_W-1:0] bmin_s3 [3][3];
	logic signed [tbo_pkg::EDOT_W-1:0] bmax_s3 [3][3];
	logic                              skip_s3 [3][3];
	logic                              bsep_s3;
	// Stage 4
	logic signed [tbo_pkg::FULL_W-1:0] full_s4 [3][3];
	logic                              esep_s4;
	logic                              bsep_s4;
	// Stage 5
	logic signed [tbo_pkg::SUM_W-1:0]  off_s5;
	logic signed [tbo_pkg::FULL_W-1:0] cmin_s5 [3];
	logic signed [tbo_pkg::FULL_W-1:0] cmax_s5 [3];
	logic                              sep_s5;
	// Stage 6
	logic signed [tbo_pkg::SUM_W-1:0]  off_s6;
	logic signed [tbo_pkg::SUM_W-1:0]  nmin_s6;
	logic signed [tbo_pkg::SUM_W-1:0]  nmax_s6;
	logic                              sep_s6;
	// Stage 7
	logic                              sep_s7;

	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && head_valid;
	assign out_valid = out_valid_q;
	assign overlaps  = overlaps_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lo[k] = box.lo[k];
			hi[k] = box.hi[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[tbo_pkg::BACK_STAGES-2:0], head_valid};
			out_valid_q <= vld_q[tbo_pkg::BACK_STAGES-1];
		end
	end

	// Stage 1: for edge i and box axis j the separating axis is e_i x u_j, with
	// components e[b] on axis a and -e[a] on axis b, where a = j+1 and b = j+2.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				np_s1[k][0] <= $signed(head.e[0][tbo_pkg::NXT1[k]])
					* $signed(head.e[1][tbo_pkg::NXT2[k]]);
				np_s1[k][1] <= $signed(head.e[0][tbo_pkg::NXT2[k]])
					* $signed(head.e[1][tbo_pkg::NXT1[k]]);
				v0_s1[k] <= head.v[0][k];
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int m = 0; m < 3; m++) begin
						tp_s1[i][j][m][0] <= $signed(head.e[i][tbo_pkg::NXT2[j]])
							* $signed(head.v[m][tbo_pkg::NXT1[j]]);
						tp_s1[i][j][m][1] <= $signed(head.e[i][tbo_pkg::NXT1[j]])
							* $signed(head.v[m][tbo_pkg::NXT2[j]]);
					end
					bp_s1[i][j][0] <= $signed(head.e[i][tbo_pkg::NXT2[j]])
						* lo[tbo_pkg::NXT1[j]];
					bp_s1[i][j][1] <= $signed(head.e[i][tbo_pkg::NXT2[j]])
						* hi[tbo_pkg::NXT1[j]];
					bp_s1[i][j][2] <= $signed(head.e[i][tbo_pkg::NXT1[j]])
						* lo[tbo_pkg::NXT2[j]];
					bp_s1[i][j][3] <= $signed(head.e[i][tbo_pkg::NXT1[j]])
						* hi[tbo_pkg::NXT2[j]];
					skip_s1[i][j] <= (head.e[i][tbo_pkg::NXT1[j]] == '0)
						&& (head.e[i][tbo_pkg::NXT2[j]] == '0);
				end
			end
			bsep_s1 <= head.box_sep;
		end
	end

	// Stage 2: plane normal, projected vertices, per-component box extremes.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				n_s2[k]  <= tbo_pkg::NRM_W'(np_s1[k][0]) - tbo_pkg::NRM_W'(np_s1[k][1]);
				v0_s2[k] <= v0_s1[k];
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					for (int m = 0; m < 3; m++) begin
						td_s2[i][j][m] <= tbo_pkg::EDOT_W'(tp_s1[i][j][m][0])
							- tbo_pkg::EDOT_W'(tp_s1[i][j][m][1]);
					end
					if (bp_s1[i][j][0] < bp_s1[i][j][1]) begin
						pq_min_s2[i][j] <= bp_s1[i][j][0];
						pq_max_s2[i][j] <= bp_s1[i][j][1];
					end else begin
						pq_min_s2[i][j] <= bp_s1[i][j][1];
						pq_max_s2[i][j] <= bp_s1[i][j][0];
					end
					if (bp_s1[i][j][2] < bp_s1[i][j][3]) begin
						rs_min_s2[i][j] <= bp_s1[i][j][2];
						rs_max_s2[i][j] <= bp_s1[i][j][3];
					end else begin
						rs_min_s2[i][j] <= bp_s1[i][j][3];
						rs_max_s2[i][j] <= bp_s1[i][j][2];
					end
					skip_s2[i][j] <= skip_s1[i][j];
				end
			end
			bsep_s2 <= bsep_s1;
		end
	end

	// Stage 3: the normal is cut into a low and a high half for the
	// second-level products; edge axes get their interval ends.
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [tbo_pkg::EDOT_W-1:0] tlo;
			logic signed [tbo_pkg::EDOT_W-1:0] thi;
			for (int k = 0; k < 3; k++) begin
				pl_s3[k][0] <= $signed({1'b0, n_s2[k][NLO-1:0]}) * v0_s2[k];
				pl_s3[k][1] <= $signed({1'b0, n_s2[k][NLO-1:0]}) * lo[k];
				pl_s3[k][2] <= $signed({1'b0, n_s2[k][NLO-1:0]}) * hi[k];
				ph_s3[k][0] <= $signed(n_s2[k][tbo_pkg::NRM_W-1:NLO]) * v0_s2[k];
				ph_s3[k][1] <= $signed(n_s2[k][tbo_pkg::NRM_W-1:NLO]) * lo[k];
				ph_s3[k][2] <= $signed(n_s2[k][tbo_pkg::NRM_W-1:NLO]) * hi[k];
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					tlo = td_s2[i][j][0];
					thi = td_s2[i][j][0];
					if ((td_s2[i][j][1] < td_s2[i][j][0]) && (td_s2[i][j][1] <= td_s2[i][j][2]))
						tlo = td_s2[i][j][1];
					else if (td_s2[i][j][2] < td_s2[i][j][0])
						tlo = td_s2[i][j][2];
					if ((td_s2[i][j][1] > td_s2[i][j][0]) && (td_s2[i][j][1] >= td_s2[i][j][2]))
						thi = td_s2[i][j][1];
					else if (td_s2[i][j][2] > td_s2[i][j][0])
						thi = td_s2[i][j][2];
					tmin_s3[i][j] <= tlo;
					tmax_s3[i][j] <= thi;
					bmin_s3[i][j] <= tbo_pkg::EDOT_W'(pq_min_s2[i][j])
						- tbo_pkg::EDOT_W'(rs_max_s2[i][j]);
					bmax_s3[i][j] <= tbo_pkg::EDOT_W'(pq_max_s2[i][j])
						- tbo_pkg::EDOT_W'(rs_min_s2[i][j]);
					skip_s3[i][j] <= skip_s2[i][j];
				end
			end
			bsep_s3 <= bsep_s2;
		end
	end

	// Stage 4: rejoin the halves; edge axes separate when the intervals only
	// touch or are apart.
	always_ff @(posedge clk) begin
		if (adv) begin
			logic es;
			es = 1'b0;
			for (int k = 0; k < 3; k++) begin
				for (int t = 0; t < 3; t++) begin
					full_s4[k][t] <= (tbo_pkg::FULL_W'(ph_s3[k][t]) <<< NLO)
						+ tbo_pkg::FULL_W'(pl_s3[k][t]);
				end
			end
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (!skip_s3[i][j] && (!(tmin_s3[i][j] < bmax_s3[i][j])
						|| !(bmin_s3[i][j] < tmax_s3[i][j]))) es = 1'b1;
				end
			end
			esep_s4 <= es;
			bsep_s4 <= bsep_s3;
		end
	end

	// Stage 5: plane offset and per-axis corner extremes.
	always_ff @(posedge clk) begin
		if (adv) begin
			off_s5 <= tbo_pkg::SUM_W'(full_s4[0][0]) + tbo_pkg::SUM_W'(full_s4[1][0])
				+ tbo_pkg::SUM_W'(full_s4[2][0]);
			for (int k = 0; k < 3; k++) begin
				if (full_s4[k][1] < full_s4[k][2]) begin
					cmin_s5[k] <= full_s4[k][1];
					cmax_s5[k] <= full_s4[k][2];
				end else begin
					cmin_s5[k] <= full_s4[k][2];
					cmax_s5[k] <= full_s4[k][1];
				end
			end
			sep_s5 <= esep_s4 || bsep_s4;
		end
	end

	// Stage 6: box projection onto the normal.
	always_ff @(posedge clk) begin
		if (adv) begin
			off_s6  <= off_s5;
			nmin_s6 <= tbo_pkg::SUM_W'(cmin_s5[0]) + tbo_pkg::SUM_W'(cmin_s5[1])
				+ tbo_pkg::SUM_W'(cmin_s5[2]);
			nmax_s6 <= tbo_pkg::SUM_W'(cmax_s5[0]) + tbo_pkg::SUM_W'(cmax_s5[1])
				+ tbo_pkg::SUM_W'(cmax_s5[2]);
			sep_s6  <= sep_s5;
		end
	end

	// Stage 7: the plane separates only when every corner is strictly on one side.
	always_ff @(posedge clk) begin
		if (adv) begin
			sep_s7     <= sep_s6 || (nmax_s6 < off_s6) || (off_s6 < nmin_s6);
			overlaps_q <= !sep_s7;
		end
	end

endmodule

`default_nettype wire

@@ design/triangle_box_overlap_test.sv @@
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Separating-axis overlap test of a triangle against a configured box.
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload
//   -------   ---------------------   ---------------------------------------
//   input     in_valid / in_stall     v0_x .. v2_z, signed Q15.8 each
//   output    out_valid / out_stall   overlaps, 1 when no axis separates
//   config    APB, psel/penable       box_min_x .. box_max_z at 4*index
//
// One word is taken per clock cycle while in_stall is low, and one result word
// leaves per cycle while out_stall is low. A word passes from acceptance
// through the queue and then the arithmetic pipeline of the back end.
// Reset clears the queue pointers, the stage valid bits and the box bounds.
// A stall on a valid result word freezes the back end; the front keeps filling the
// four-entry queue and raises in_stall only once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_box_overlap_test (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  tbo_pkg::coord_t              v0_x,
	input  tbo_pkg::coord_t              v0_y,
	input  tbo_pkg::coord_t              v0_z,
	input  tbo_pkg::coord_t              v1_x,
	input  tbo_pkg::coord_t              v1_y,
	input  tbo_pkg::coord_t              v1_z,
	input  tbo_pkg::coord_t              v2_x,
	input  tbo_pkg::coord_t              v2_y,
	input  tbo_pkg::coord_t              v2_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         overlaps,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tbo_pkg::ADDR_W-1:0]   paddr,
	input  logic [tbo_pkg::APB_W-1:0]    pwdata,
	output logic [tbo_pkg::APB_W-1:0]    prdata,
	output logic                         pready
);

	tbo_pkg::coord_t box_lo_q [3];
	tbo_pkg::coord_t box_hi_q [3];
	tbo_pkg::box_t   box;
	tbo_pkg::item_t  front_item;
	tbo_pkg::item_t  head;
	logic            q_full;
	logic            q_empty;
	logic            pop;
	logic            wr_en;
	logic [tbo_pkg::REG_IDX_W-1:0] reg_idx;
	tbo_pkg::coord_t wdata;

	// The write strobe is the APB access phase; pready never drops, so no
	// wait states are inserted.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[tbo_pkg::ADDR_W-1:2];
	assign wdata   = pwdata[tbo_pkg::COORD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				box_lo_q[k] <= '0;
				box_hi_q[k] <= '0;
			end
		end else if (wr_en) begin
			unique case (reg_idx)
				tbo_pkg::REG_MIN_X: box_lo_q[0] <= wdata;
				tbo_pkg::REG_MAX_X: box_hi_q[0] <= wdata;
				tbo_pkg::REG_MIN_Y: box_lo_q[1] <= wdata;
				tbo_pkg::REG_MAX_Y: box_hi_q[1] <= wdata;
				tbo_pkg::REG_MIN_Z: box_lo_q[2] <= wdata;
				tbo_pkg::REG_MAX_Z: box_hi_q[2] <= wdata;
				default: ;
			endcase
		end
	end

	// Read data is the bound sign-extended to the bus width; unused
	// addresses read as zero.
	always_comb begin
		unique case (reg_idx)
			tbo_pkg::REG_MIN_X: prdata = tbo_pkg::APB_W'(box_lo_q[0]);
			tbo_pkg::REG_MAX_X: prdata = tbo_pkg::APB_W'(box_hi_q[0]);
			tbo_pkg::REG_MIN_Y: prdata = tbo_pkg::APB_W'(box_lo_q[1]);
			tbo_pkg::REG_MAX_Y: prdata = tbo_pkg::APB_W'(box_hi_q[1]);
			tbo_pkg::REG_MIN_Z: prdata = tbo_pkg::APB_W'(box_lo_q[2]);
			tbo_pkg::REG_MAX_Z: prdata = tbo_pkg::APB_W'(box_hi_q[2]);
			default:            prdata = '0;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			box.lo[k] = box_lo_q[k];
			box.hi[k] = box_hi_q[k];
		end
	end

	// The front end works out the edge vectors and the box-axis verdict in
	// the cycle the word arrives, so the queue holds classified words.
	tbo_front u_front (
		.v0_x (v0_x),
		.v0_y (v0_y),
		.v0_z (v0_z),
		.v1_x (v1_x),
		.v1_y (v1_y),
		.v1_z (v1_z),
		.v2_x (v2_x),
		.v2_y (v2_y),
		.v2_z (v2_z),
		.box  (box),
		.item (front_item)
	);

	assign in_stall = q_full;

	tbo_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_valid),
		.din    (front_item),
		.pop    (pop),
		.dout   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The back end carries the plane-normal and edge-axis arithmetic; it moves only when
	// its output register is free or being emptied.
	tbo_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_empty),
		.box        (box),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.overlaps   (overlaps)
	);

endmodule

`default_nettype wire

@@ design/tbo_checker.sv @@
// ----------------------------------------------------------------------------
// tbo_checker
// Port-level checks of the overlap test: handshake and word accounting.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tbo_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic overlaps
);

	logic                        in_acc;
	logic                        out_acc;
	logic [tbo_pkg::OCNT_W-1:0]  cnt_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + tbo_pkg::OCNT_W'(in_acc) - tbo_pkg::OCNT_W'(out_acc);
		end
	end

	`TBO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
	`TBO_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(overlaps), "stalled result changed")
	`TBO_ASSERT(a_no_invent, out_valid |-> (cnt_q != '0), "result word without an accepted input")
	`TBO_ASSERT(a_capacity, cnt_q <= tbo_pkg::OCNT_W'(tbo_pkg::CAPACITY), "more words in flight than storage")
	`TBO_ASSERT(a_empty_ready, (cnt_q == '0) |-> !in_stall, "input stalled while the block is empty")

endmodule

bind triangle_box_overlap_test tbo_checker u_tbo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.overlaps  (overlaps)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle/box separating-axis overlap test.
// Triangles are streamed through the block against a series of box settings
// written over APB: the reset box, ordinary boxes, the full coordinate range,
// inverted and flat boxes. Each accepted triangle is run through an exact
// wide-integer predictor, and every result word is compared with the oldest
// prediction. Both channels idle at random, with some phases at full rate.
// ----------------------------------------------------------------------------

module testbench;

	typedef logic signed [127:0] wide_t;
	typedef tbo_pkg::coord_t tri_t [3][3];

	localparam int ITEM_TOTAL = 1000;
	localparam int PHASES     = 8;
	// Indexes past the last box register; writes there must be ignored.
	localparam int REG_SPARE_A = 6;
	localparam int REG_SPARE_B = 7;
	localparam longint COORD_MAX = 64'sd8388607;
	localparam longint COORD_MIN = -64'sd8388608;

	// ------------------------------------------------------------------------
	// Scoreboard: keeps its own copy of the box, predicts the overlap flag of
	// every accepted triangle and matches the result words in order.
	// ------------------------------------------------------------------------
	class overlap_scoreboard;
		tbo_pkg::coord_t box_reg [tbo_pkg::REG_NUM];
		bit     flag_q [$];
		int     mismatches;
		int     checked;
		int     hits;

		function new();
			foreach (box_reg[i]) box_reg[i] = '0;
			mismatches = 0;
			checked = 0;
			hits = 0;
		endfunction

		function void set_reg(int idx, tbo_pkg::coord_t val);
			if (idx < tbo_pkg::REG_NUM) box_reg[idx] = val;
		endfunction

		// Projection interval of the box on an axis; corners are taken from
		// both bounds on every axis, so an inverted box is handled as written.
		function void box_span(wide_t ax [3], output wide_t mn, output wide_t mx);
			wide_t p, q;
			mn = 0;
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				p = ax[i] * wide_t'(box_reg[2*i]);
				q = ax[i] * wide_t'(box_reg[2*i+1]);
				if (p < q) begin
					mn += p;
					mx += q;
				end else begin
					mn += q;
					mx += p;
				end
			end
		endfunction

		function wide_t dot(wide_t ax [3], tri_t t, int k);
			return ax[0] * wide_t'(t[k][0]) + ax[1] * wide_t'(t[k][1])
				+ ax[2] * wide_t'(t[k][2]);
		endfunction

		function bit overlap_of(tri_t t);
			wide_t ax [3];
			wide_t bmin, bmax, tmin, tmax, d, off;
			longint a [3], b [3], e [3];
			longint mn, mx;
			for (int i = 0; i < 3; i++) begin
				mn = t[0][i];
				mx = t[0][i];
				for (int k = 1; k < 3; k++) begin
					if (t[k][i] < mn) mn = t[k][i];
					if (t[k][i] > mx) mx = t[k][i];
				end
				if (mx < longint'(box_reg[2*i]) || mn > longint'(box_reg[2*i+1]))
					return 1'b0;
			end
			for (int i = 0; i < 3; i++) begin
				a[i] = longint'(t[1][i]) - longint'(t[0][i]);
				b[i] = longint'(t[2][i]) - longint'(t[1][i]);
			end
			ax[0] = wide_t'(a[1] * b[2] - a[2] * b[1]);
			ax[1] = wide_t'(a[2] * b[0] - a[0] * b[2]);
			ax[2] = wide_t'(a[0] * b[1] - a[1] * b[0]);
			off = dot(ax, t, 0);
			box_span(ax, bmin, bmax);
			if (bmax < off || off < bmin) return 1'b0;
			// Edge-by-box-axis cross products; touching separates here.
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++)
					e[k] = longint'(t[i][k]) - longint'(t[(i+1)%3][k]);
				for (int j = 0; j < 3; j++) begin
					case (j)
						0: begin ax[0] = 0; ax[1] = e[2]; ax[2] = -e[1]; end
						1: begin ax[0] = -e[2]; ax[1] = 0; ax[2] = e[0]; end
						default: begin ax[0] = e[1]; ax[1] = -e[0]; ax[2] = 0; end
					endcase
					if (ax[0] == 0 && ax[1] == 0 && ax[2] == 0) continue;
					box_span(ax, bmin, bmax);
					tmin = dot(ax, t, 0);
					tmax = tmin;
					for (int k = 1; k < 3; k++) begin
						d = dot(ax, t, k);
						if (d < tmin) tmin = d;
						if (d > tmax) tmax = d;
					end
					if (!(tmin < bmax) || !(bmin < tmax)) return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function void note_triangle(tri_t t);
			flag_q = {flag_q, overlap_of(t)};
		endfunction

		function void check_flag(logic got);
			bit want;
			checked++;
			if (got === 1'b1) hits++;
			if (flag_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result word, overlaps=%b", $realtime, got);
				return;
			end
			want = flag_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: overlaps mismatch, expected %b, got %b",
						$realtime, want, got);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Signals and the block itself.
	// ------------------------------------------------------------------------
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	tbo_pkg::coord_t v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
	logic out_valid;
	logic out_stall;
	logic overlaps;
	logic psel, penable, pwrite;
	logic [tbo_pkg::ADDR_W-1:0] paddr;
	logic [tbo_pkg::APB_W-1:0]  pwdata;
	logic [tbo_pkg::APB_W-1:0]  prdata;
	logic pready;

	overlap_scoreboard sb;
	int  sent;
	bit  full_rate;

	triangle_box_overlap_test dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.v0_x(v0_x), .v0_y(v0_y), .v0_z(v0_z),
		.v1_x(v1_x), .v1_y(v1_y), .v1_z(v1_z),
		.v2_x(v2_x), .v2_y(v2_y), .v2_z(v2_z),
		.out_valid(out_valid), .out_stall(out_stall), .overlaps(overlaps),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A generous ceiling: a thousand words at worst-case idling on both sides
	// take well under a tenth of this.
	initial begin
		#3ms;
		$display("** triangle_box_overlap_test: FAILED **");
		$finish;
	end

	// Result words are checked at the edge that accepts them. The values read
	// here are those from before the edge, so no ordering race arises.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_flag(overlaps);
	end

	// The receiving side stalls for a random number of cycles before each
	// word, except in full-rate phases where it takes every word at once.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			n = full_rate ? 0 : $urandom_range(7);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// ------------------------------------------------------------------------
	// Driving tasks.
	// ------------------------------------------------------------------------
	task automatic write_reg(int idx, longint val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= tbo_pkg::ADDR_W'(4 * idx);
		pwdata  <= tbo_pkg::APB_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, tbo_pkg::coord_t'(val));
	endtask

	task automatic set_box(longint x0, longint x1, longint y0, longint y1,
			longint z0, longint z1);
		write_reg(tbo_pkg::REG_MIN_X, x0);
		write_reg(tbo_pkg::REG_MAX_X, x1);
		write_reg(tbo_pkg::REG_MIN_Y, y0);
		write_reg(tbo_pkg::REG_MAX_Y, y1);
		write_reg(tbo_pkg::REG_MIN_Z, z0);
		write_reg(tbo_pkg::REG_MAX_Z, z1);
	endtask

	// Sends one word after a random gap; valid stays high across words sent
	// back to back.
	task automatic send_triangle(tri_t t);
		int gap;
		gap = full_rate ? 0 : $urandom_range(7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		v0_x <= t[0][0]; v0_y <= t[0][1]; v0_z <= t[0][2];
		v1_x <= t[1][0]; v1_y <= t[1][1]; v1_z <= t[1][2];
		v2_x <= t[2][0]; v2_y <= t[2][1]; v2_z <= t[2][2];
		do @(posedge clk); while (in_stall);
		sb.note_triangle(t);
		sent++;
	endtask

	// Waits until every result has come back, then lets the pipeline drain.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.flag_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic tbo_pkg::coord_t clamp(longint x);
		if (x > COORD_MAX) return tbo_pkg::coord_t'(COORD_MAX);
		if (x < COORD_MIN) return tbo_pkg::coord_t'(COORD_MIN);
		return tbo_pkg::coord_t'(x);
	endfunction

	// A coordinate near the current box on one axis, so that all outcomes
	// occur; a fifth of the time a fully random value instead.
	function automatic tbo_pkg::coord_t near_box(int axis);
		longint lo, hi, span;
		lo = sb.box_reg[2*axis];
		hi = sb.box_reg[2*axis+1];
		if (lo > hi) begin
			span = lo;
			lo = hi;
			hi = span;
		end
		span = (hi - lo) / 2 + 16;
		if ($urandom_range(4) == 0) return tbo_pkg::coord_t'($urandom);
		if ($urandom_range(9) == 0) return clamp($urandom_range(1) ? lo : hi);
		return clamp(lo - span + longint'($urandom_range(32'(hi - lo + 2 * span))));
	endfunction

	function automatic tri_t random_triangle();
		tri_t t;
		int shape;
		shape = $urandom_range(9);
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 3; i++)
				t[k][i] = near_box(i);
		// Now and then a degenerate triangle: a repeated vertex, or an edge
		// parallel to a box axis.
		if (shape == 0) t[2] = t[0];
		else if (shape == 1) begin
			t[1][1] = t[0][1];
			t[1][2] = t[0][2];
		end
		return t;
	endfunction

	function automatic tri_t make_tri(longint a0, longint a1, longint a2,
			longint b0, longint b1, longint b2, longint c0, longint c1, longint c2);
		tri_t t;
		t[0][0] = clamp(a0); t[0][1] = clamp(a1); t[0][2] = clamp(a2);
		t[1][0] = clamp(b0); t[1][1] = clamp(b1); t[1][2] = clamp(b2);
		t[2][0] = clamp(c0); t[2][1] = clamp(c1); t[2][2] = clamp(c2);
		return t;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		tri_t t;
		longint a, b;
		sb = new();
		sent = 0;
		full_rate = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		{v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The reset box is a single point at the origin.
		send_triangle(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_triangle(make_tri(-256, -256, 0, 256, -256, 0, 0, 256, 0));
		send_triangle(make_tri(1, 1, 1, 2, 1, 1, 1, 2, 1));
		drain();

		// Directed words against a box 4.0 wide on each axis.
		set_box(-512, 512, -512, 512, -512, 512);
		// Out-of-range indexes must leave the box alone.
		write_reg(REG_SPARE_A, 32'h00123456);
		write_reg(REG_SPARE_B, -1);
		send_triangle(make_tri(0, 0, 0, 100, 0, 0, 0, 100, 0));
		send_triangle(make_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
		send_triangle(make_tri(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
		send_triangle(make_tri(COORD_MIN, COORD_MIN, 0, COORD_MAX, COORD_MIN, 0,
			0, COORD_MAX, 0));
		send_triangle(make_tri(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN));
		// Touching a face from outside on the x and y axes: still overlapping; just clear of the z face.
		send_triangle(make_tri(512, 0, 0, 900, 0, 0, 900, 100, 0));
		send_triangle(make_tri(0, -512, 0, 0, -900, 0, 100, -900, 0));
		send_triangle(make_tri(0, 0, 513, 0, 100, 900, 100, 0, 900));
		// Two planes beyond the far corner, the second a step further out.
		send_triangle(make_tri(1536, 512, 512, 512, 1536, 512, 512, 512, 1536));
		send_triangle(make_tri(1537, 512, 512, 512, 1537, 512, 512, 512, 1537));
		// An edge running diagonally past a box edge: edge axes decide.
		send_triangle(make_tri(1024, 0, 0, 0, 1024, 0, 600, 600, 400));
		send_triangle(make_tri(1025, 0, 0, 0, 1025, 0, 1025, 1025, 700));
		// Degenerate triangles: a point inside, a point outside, two lines.
		send_triangle(make_tri(10, 10, 10, 10, 10, 10, 10, 10, 10));
		send_triangle(make_tri(600, 10, 10, 600, 10, 10, 600, 10, 10));
		send_triangle(make_tri(-700, -700, 0, 0, 0, 0, 700, 700, 0));
		send_triangle(make_tri(-700, 700, 300, 0, 0, 900, 700, -700, 1500));
		// A large triangle enclosing the box in its plane.
		send_triangle(make_tri(-5000, -5000, 0, 5000, -5000, 0, 0, 5000, 0));
		drain();

		// Random phases, each with its own box. Some run at full rate.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
					COORD_MIN, COORD_MAX);
				1: set_box(256, -256, -1024, 1024, 300, 200);
				2: set_box(0, 0, -100, 100, 50, 50);
				3: set_box(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0, 1);
				default: begin
					for (int i = 0; i < 3; i++) begin
						a = longint'(tbo_pkg::coord_t'($urandom)) >>> $urandom_range(16);
						b = a + longint'($urandom_range(1 << $urandom_range(18)));
						write_reg(2 * i, a);
						write_reg(2 * i + 1, clamp(b));
					end
				end
			endcase
			full_rate = (ph % 3 == 2);
			for (int n = 0; n < ITEM_TOTAL / PHASES; n++) begin
				t = random_triangle();
				send_triangle(t);
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Sent %0d triangles over %0d box settings; %0d results checked, %0d overlapping.",
			sent, PHASES + 2, sb.checked, sb.hits);
		$display("Mismatches: %0d, predictions left over: %0d.",
			sb.mismatches, sb.flag_q.size());
		if (sb.mismatches == 0 && sb.flag_q.size() == 0)
			$display("** triangle_box_overlap_test: PASSED **");
		else
			$display("** triangle_box_overlap_test: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/tbo_pkg.sv
design/tbo_front.sv
design/tbo_queue.sv
design/tbo_back.sv
design/triangle_box_overlap_test.sv
design/tbo_checker.sv
sim/testbench.sv
